[sv/line_follower_right_hand_steering_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the line follower steering block
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOWER_RIGHT_HAND_STEERING_ASSERT_SVH
`define LINE_FOLLOWER_RIGHT_HAND_STEERING_ASSERT_SVH

// same-cycle implication
`define LFRHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFRHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lfrhs_pkg.sv]
// ----------------------------------------------------------------------------
// lfrhs_pkg
// Types, codes and constants of the right-hand-rule steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfrhs_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int SAMPLE_W     = 10;
    localparam int TIME_W       = 32;
    localparam int RANGE_W      = 9;
    localparam int CMD_W        = 3;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_W    = 3;
    localparam int DARK_CNT_W   = 4;

    localparam logic [RANGE_W-1:0] RANGE_CAP = 9'd300;

    typedef enum logic [CMD_W-1:0] {
        CMD_HOLD     = 3'd0,
        CMD_FORWARD  = 3'd1,
        CMD_RIGHT    = 3'd2,
        CMD_LEFT     = 3'd3,
        CMD_UTURN    = 3'd4,
        CMD_OBSTACLE = 3'd5,
        CMD_FINISH   = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        HEAD_STRAIGHT = 2'd0,
        HEAD_RIGHT    = 2'd1,
        HEAD_LEFT     = 2'd2
    } head_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DARK_THRESHOLD  = 3'd0,
        REG_FINISH_MIN_DARK = 3'd1,
        REG_FINISH_HOLD_MS  = 3'd2,
        REG_OBSTACLE_LIMIT  = 3'd3,
        REG_CHECK_INTERVAL  = 3'd4,
        REG_TURN_COMMIT     = 3'd5,
        REG_RIGHT_CONFIRM   = 3'd6
    } reg_idx_t;

    localparam logic [9:0]  RST_DARK_THRESHOLD  = 10'd850;
    localparam logic [3:0]  RST_FINISH_MIN_DARK = 4'd6;
    localparam logic [15:0] RST_FINISH_HOLD_MS  = 16'd135;
    localparam logic [8:0]  RST_OBSTACLE_LIMIT  = 9'd13;
    localparam logic [15:0] RST_CHECK_INTERVAL  = 16'd100;
    localparam logic [7:0]  RST_TURN_COMMIT     = 8'd20;
    localparam logic [2:0]  RST_RIGHT_CONFIRM   = 3'd2;

    typedef struct packed {
        logic [9:0]  dark_threshold;
        logic [3:0]  finish_min_dark;
        logic [15:0] finish_hold_ms;
        logic [8:0]  obstacle_limit_cm;
        logic [15:0] check_interval_ms;
        logic [7:0]  turn_commit_steps;
        logic [2:0]  right_confirm_steps;
    } cfg_t;

    typedef struct packed {
        logic [SENSOR_COUNT-1:0][SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]                     now_ms;
        logic [RANGE_W-1:0]                    range_cm;
    } item_t;

    typedef struct packed {
        cmd_t command;
        logic finished;
    } result_t;

endpackage

`default_nettype wire

[sv/lfrhs_if.sv]
// ----------------------------------------------------------------------------
// lfrhs_in_if / lfrhs_out_if
// Valid/ready channels for sensor frames and steering commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfrhs_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] sample_0;
    logic [9:0] sample_1;
    logic [9:0] sample_2;
    logic [9:0] sample_3;
    logic [9:0] sample_4;
    logic [9:0] sample_5;
    logic [9:0] sample_6;
    logic [9:0] sample_7;
    logic [31:0] now_ms;
    logic [8:0]  range_cm;

    modport source (
        output valid, sample_0, sample_1, sample_2, sample_3,
               sample_4, sample_5, sample_6, sample_7, now_ms, range_cm,
        input  ready
    );
    modport sink (
        input  valid, sample_0, sample_1, sample_2, sample_3,
               sample_4, sample_5, sample_6, sample_7, now_ms, range_cm,
        output ready
    );
endinterface

interface lfrhs_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic       finished;

    modport source (
        output valid, command, finished,
        input  ready
    );
    modport sink (
        input  valid, command, finished,
        output ready
    );
endinterface

`default_nettype wire

[sv/lfrhs_cfg.sv]
// ----------------------------------------------------------------------------
// lfrhs_cfg
// APB register bank holding the steering thresholds and step counts.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrhs_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lfrhs_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [lfrhs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [lfrhs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready,
    output lfrhs_pkg::cfg_t                        cfg
);
    import lfrhs_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_DARK_THRESHOLD:  cfg_next.dark_threshold      = pwdata[9:0];
                REG_FINISH_MIN_DARK: cfg_next.finish_min_dark     = pwdata[3:0];
                REG_FINISH_HOLD_MS:  cfg_next.finish_hold_ms      = pwdata[15:0];
                REG_OBSTACLE_LIMIT:  cfg_next.obstacle_limit_cm   = pwdata[8:0];
                REG_CHECK_INTERVAL:  cfg_next.check_interval_ms   = pwdata[15:0];
                REG_TURN_COMMIT:     cfg_next.turn_commit_steps   = pwdata[7:0];
                REG_RIGHT_CONFIRM:   cfg_next.right_confirm_steps = pwdata[2:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DARK_THRESHOLD:  prdata = {22'd0, cfg_reg.dark_threshold};
            REG_FINISH_MIN_DARK: prdata = {28'd0, cfg_reg.finish_min_dark};
            REG_FINISH_HOLD_MS:  prdata = {16'd0, cfg_reg.finish_hold_ms};
            REG_OBSTACLE_LIMIT:  prdata = {23'd0, cfg_reg.obstacle_limit_cm};
            REG_CHECK_INTERVAL:  prdata = {16'd0, cfg_reg.check_interval_ms};
            REG_TURN_COMMIT:     prdata = {24'd0, cfg_reg.turn_commit_steps};
            REG_RIGHT_CONFIRM:   prdata = {29'd0, cfg_reg.right_confirm_steps};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_threshold      <= RST_DARK_THRESHOLD;
            cfg_reg.finish_min_dark     <= RST_FINISH_MIN_DARK;
            cfg_reg.finish_hold_ms      <= RST_FINISH_HOLD_MS;
            cfg_reg.obstacle_limit_cm   <= RST_OBSTACLE_LIMIT;
            cfg_reg.check_interval_ms   <= RST_CHECK_INTERVAL;
            cfg_reg.turn_commit_steps   <= RST_TURN_COMMIT;
            cfg_reg.right_confirm_steps <= RST_RIGHT_CONFIRM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[sv/lfrhs_core.sv]
// ----------------------------------------------------------------------------
// lfrhs_core
// Navigation state and the combinational steering decision for one frame.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrhs_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  lfrhs_pkg::item_t        item,
    input  lfrhs_pkg::cfg_t         cfg,
    output lfrhs_pkg::result_t      result
);
    import lfrhs_pkg::*;

    logic              done_reg,      done_next;
    logic              timing_reg,    timing_next;
    logic [TIME_W-1:0] sq_start_reg,  sq_start_next;
    logic [TIME_W-1:0] last_chk_reg,  last_chk_next;
    logic              turning_reg,   turning_next;
    head_t             heading_reg,   heading_next;
    logic [2:0]        right_seen_reg, right_seen_next;
    logic [7:0]        commit_reg,    commit_next;

    logic [SENSOR_COUNT-1:0] dark;
    logic [DARK_CNT_W-1:0]   dark_count;
    logic [TIME_W-1:0]       chk_elapsed;
    logic [TIME_W-1:0]       sq_elapsed;
    logic                    chk_due;
    logic                    obstacle;
    logic                    square;
    logic                    finish_hit;
    logic                    right_g;
    logic                    center_g;
    logic                    left_g;
    logic [7:0]              commit_inc;
    logic [2:0]              right_inc;
    cmd_t                    turn_cmd;

    always_comb
    begin
        dark_count = '0;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            dark[i]    = item.sample[i] > cfg.dark_threshold;
            dark_count = dark_count + DARK_CNT_W'(dark[i]);
        end
    end

    assign chk_elapsed = item.now_ms - last_chk_reg;
    assign sq_elapsed  = item.now_ms - sq_start_reg;
    assign chk_due     = chk_elapsed >= {16'd0, cfg.check_interval_ms};
    assign obstacle    = chk_due && (item.range_cm != '0)
                         && (item.range_cm < cfg.obstacle_limit_cm)
                         && (item.range_cm < RANGE_CAP);
    assign square      = dark_count >= cfg.finish_min_dark;
    assign finish_hit  = square && timing_reg && (sq_elapsed >= {16'd0, cfg.finish_hold_ms});

    assign right_g  = |dark[2:0];
    assign center_g = |dark[4:3];
    assign left_g   = |dark[7:5];

    assign commit_inc = (commit_reg == 8'hFF) ? commit_reg : commit_reg + 8'd1;
    assign right_inc  = (right_seen_reg == 3'h7) ? right_seen_reg : right_seen_reg + 3'd1;

    always_comb
    begin
        case (heading_reg)
            HEAD_RIGHT: turn_cmd = CMD_RIGHT;
            HEAD_LEFT:  turn_cmd = CMD_LEFT;
            default:    turn_cmd = CMD_HOLD;
        endcase
    end

    always_comb
    begin
        done_next       = done_reg;
        timing_next     = timing_reg;
        sq_start_next   = sq_start_reg;
        last_chk_next   = last_chk_reg;
        turning_next    = turning_reg;
        heading_next    = heading_reg;
        right_seen_next = right_seen_reg;
        commit_next     = commit_reg;
        result.command  = CMD_HOLD;
        result.finished = 1'b0;

        if (done_reg)
        begin
            result.finished = 1'b1;
        end
        else
        begin
            if (chk_due)
            begin
                last_chk_next = item.now_ms;
            end
            if (obstacle)
            begin
                turning_next    = 1'b0;
                heading_next    = HEAD_STRAIGHT;
                right_seen_next = '0;
                commit_next     = '0;
                result.command  = CMD_OBSTACLE;
            end
            else if (finish_hit)
            begin
                done_next       = 1'b1;
                result.command  = CMD_FINISH;
                result.finished = 1'b1;
            end
            else
            begin
                if (square)
                begin
                    if (!timing_reg)
                    begin
                        timing_next   = 1'b1;
                        sq_start_next = item.now_ms;
                    end
                end
                else
                begin
                    timing_next = 1'b0;
                end

                if (turning_reg)
                begin
                    commit_next    = commit_inc;
                    result.command = turn_cmd;
                    if ((commit_inc >= cfg.turn_commit_steps) && center_g && !right_g && !left_g)
                    begin
                        turning_next    = 1'b0;
                        heading_next    = HEAD_STRAIGHT;
                        right_seen_next = '0;
                        commit_next     = '0;
                        result.command  = CMD_FORWARD;
                    end
                end
                else
                begin
                    right_seen_next = right_g ? right_inc : 3'd0;
                    if (right_g && (right_inc >= cfg.right_confirm_steps))
                    begin
                        turning_next   = 1'b1;
                        heading_next   = HEAD_RIGHT;
                        result.command = CMD_RIGHT;
                    end
                    else if (center_g)
                    begin
                        heading_next   = HEAD_STRAIGHT;
                        result.command = CMD_FORWARD;
                    end
                    else if (left_g)
                    begin
                        turning_next   = 1'b1;
                        heading_next   = HEAD_LEFT;
                        result.command = CMD_LEFT;
                    end
                    else if (!right_g)
                    begin
                        result.command = CMD_UTURN;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg       <= 1'b0;
            timing_reg     <= 1'b0;
            sq_start_reg   <= '0;
            last_chk_reg   <= '0;
            turning_reg    <= 1'b0;
            heading_reg    <= HEAD_STRAIGHT;
            right_seen_reg <= '0;
            commit_reg     <= '0;
        end
        else if (step)
        begin
            done_reg       <= done_next;
            timing_reg     <= timing_next;
            sq_start_reg   <= sq_start_next;
            last_chk_reg   <= last_chk_next;
            turning_reg    <= turning_next;
            heading_reg    <= heading_next;
            right_seen_reg <= right_seen_next;
            commit_reg     <= commit_next;
        end
    end

endmodule

`default_nettype wire

[sv/line_follower_right_hand_steering.sv]
// ----------------------------------------------------------------------------
// line_follower_right_hand_steering
// Right-hand-rule steering for a line follower robot.
//
// in_ch carries one sensor frame per transaction: eight line samples, a
// millisecond timestamp and an ultrasonic range. out_ch returns one
// transaction per frame: a steering command and the latched finish flag.
// Thresholds and step counts sit in an APB register bank; write them only
// while no frame is in flight.
// A frame is captured into an input register, then decided by combinational
// logic into an output register that drives out valid.
// One frame per cycle is sustained while out_ch is ready; the decision
// logic is the only step. When out_ch stalls the result holds and one
// more frame waits in the input register; in_ch drops ready only when
// both are full. Reset clears the navigation state, the finish flag, both
// pipeline valids and loads the registers with their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follower_right_hand_steering (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    lfrhs_in_if.sink                               in_ch,
    lfrhs_out_if.source                            out_ch,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lfrhs_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [lfrhs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [lfrhs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready
);
    import lfrhs_pkg::*;
    `include "line_follower_right_hand_steering_assert.svh"

    cfg_t    cfg;
    item_t   item_reg;
    result_t result;
    result_t res_reg;
    logic    in_valid_reg,  in_valid_next;
    logic    out_valid_reg, out_valid_next;
    logic    in_ready;
    logic    in_take;
    logic    advance;

    lfrhs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lfrhs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ready     = !in_valid_reg || advance;
    assign in_take      = in_ch.valid && in_ready;
    assign in_ch.ready  = in_ready;

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.command  = res_reg.command;
    assign out_ch.finished = res_reg.finished;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.sample[0] <= in_ch.sample_0;
            item_reg.sample[1] <= in_ch.sample_1;
            item_reg.sample[2] <= in_ch.sample_2;
            item_reg.sample[3] <= in_ch.sample_3;
            item_reg.sample[4] <= in_ch.sample_4;
            item_reg.sample[5] <= in_ch.sample_5;
            item_reg.sample[6] <= in_ch.sample_6;
            item_reg.sample[7] <= in_ch.sample_7;
            item_reg.now_ms    <= in_ch.now_ms;
            item_reg.range_cm  <= in_ch.range_cm;
        end
        if (advance)
        begin
            res_reg <= result;
        end
    end

    `LFRHS_ASSERT_NOW(a_fin_cmd, out_valid_reg && res_reg.finished,
        (res_reg.command == CMD_HOLD) || (res_reg.command == CMD_FINISH),
        "finished result with a motion command")
    `LFRHS_ASSERT_NOW(a_finish_flag, out_valid_reg && (res_reg.command == CMD_FINISH),
        res_reg.finished, "finish command without finished flag")
    `LFRHS_ASSERT_NEXT(a_advance_out, advance, out_valid_reg, "decided frame not presented")
    `LFRHS_ASSERT_NOW(a_no_deadlock, !out_valid_reg, in_ready, "input stalled with empty output")

endmodule

`default_nettype wire

[verif/line_follower_right_hand_steering_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_follower_right_hand_steering_test
// Self-checking bench for the right-hand-rule steering block. Sensor frames
// are built from line patterns (straight, right and left branches, dead ends,
// finish squares, close echoes, noise). An in-bench steering model predicts
// the command for every accepted frame. Returned transactions are compared
// field by field, in order. Register settings are swept between phases over
// APB, and both channels are throttled at random.
// ----------------------------------------------------------------------------

module line_follower_right_hand_steering_test;

    import lfrhs_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef enum {LVL_RANDOM, LVL_EXTREME, LVL_EDGE, LVL_RAW} level_t;
    typedef enum {SEG_STRAIGHT, SEG_RIGHT, SEG_LEFT, SEG_DEAD_END,
                  SEG_SQUARE, SEG_OBSTACLE, SEG_NOISE} seg_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lfrhs_in_if  in_ch ();
    lfrhs_out_if out_ch ();

    line_follower_right_hand_steering DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // steering model state
    cfg_t        steer_cfg;
    logic        nav_done;
    logic        sq_timing;
    logic [31:0] sq_start_ms;
    logic [31:0] last_check_ms;
    logic        nav_turning;
    head_t       nav_heading;
    logic [2:0]  right_hits;
    logic [7:0]  turn_age;

    result_t     expected_cmds[$];
    int unsigned error_count;
    int unsigned results_seen;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic [31:0] track_ms;

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    function automatic cfg_t steer_settings(input int unsigned thr, dark_needed, hold,
                                            obst, interval, commit, confirm);
        cfg_t c;
        c.dark_threshold      = 10'(thr);
        c.finish_min_dark     = 4'(dark_needed);
        c.finish_hold_ms      = 16'(hold);
        c.obstacle_limit_cm   = 9'(obst);
        c.check_interval_ms   = 16'(interval);
        c.turn_commit_steps   = 8'(commit);
        c.right_confirm_steps = 3'(confirm);
        return c;
    endfunction

    function automatic void drop_navigation();
        nav_turning = 1'b0;
        nav_heading = HEAD_STRAIGHT;
        right_hits  = '0;
        turn_age    = '0;
    endfunction

    function automatic cmd_t heading_cmd();
        case (nav_heading)
            HEAD_RIGHT: return CMD_RIGHT;
            HEAD_LEFT:  return CMD_LEFT;
            default:    return CMD_HOLD;
        endcase
    endfunction

    function automatic result_t steer_predict(input item_t fr);
        result_t                 res;
        logic [SENSOR_COUNT-1:0] dark;
        int unsigned             dark_total;
        logic [31:0]             elapsed;
        logic                    on_right;
        logic                    on_center;
        logic                    on_left;
        logic                    decided;
        res.command  = CMD_HOLD;
        res.finished = 1'b0;
        dark_total   = 0;
        decided      = 1'b0;
        if (nav_done)
        begin
            res.finished = 1'b1;
            return res;
        end
        elapsed = fr.now_ms - last_check_ms;
        if (elapsed >= steer_cfg.check_interval_ms)
        begin
            last_check_ms = fr.now_ms;
            if (fr.range_cm != 0 && fr.range_cm < steer_cfg.obstacle_limit_cm
                && fr.range_cm < RANGE_CAP)
            begin
                drop_navigation();
                res.command = CMD_OBSTACLE;
                return res;
            end
        end
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            dark[i] = fr.sample[i] > steer_cfg.dark_threshold;
            dark_total += dark[i];
        end
        if (dark_total >= steer_cfg.finish_min_dark)
        begin
            if (!sq_timing)
            begin
                sq_timing   = 1'b1;
                sq_start_ms = fr.now_ms;
            end
            else
            begin
                elapsed = fr.now_ms - sq_start_ms;
                if (elapsed >= steer_cfg.finish_hold_ms)
                begin
                    nav_done     = 1'b1;
                    res.command  = CMD_FINISH;
                    res.finished = 1'b1;
                    return res;
                end
            end
        end
        else
            sq_timing = 1'b0;
        on_right  = |dark[2:0];
        on_center = |dark[4:3];
        on_left   = |dark[7:5];
        if (nav_turning)
        begin
            if (turn_age != 8'hFF)
                turn_age++;
            if (turn_age < steer_cfg.turn_commit_steps)
                res.command = heading_cmd();
            else if (on_center && !on_right && !on_left)
            begin
                drop_navigation();
                res.command = CMD_FORWARD;
            end
            else
                res.command = heading_cmd();
        end
        else
        begin
            if (on_right)
            begin
                if (right_hits != 3'd7)
                    right_hits++;
                if (right_hits >= steer_cfg.right_confirm_steps)
                begin
                    nav_turning = 1'b1;
                    nav_heading = HEAD_RIGHT;
                    res.command = CMD_RIGHT;
                    decided     = 1'b1;
                end
            end
            else
                right_hits = '0;
            if (!decided)
            begin
                if (on_center)
                begin
                    nav_heading = HEAD_STRAIGHT;
                    res.command = CMD_FORWARD;
                end
                else if (on_left)
                begin
                    nav_turning = 1'b1;
                    nav_heading = HEAD_LEFT;
                    res.command = CMD_LEFT;
                end
                else if (!on_right)
                    res.command = CMD_UTURN;
            end
        end
        return res;
    endfunction

    // frame generation
    function automatic item_t build_frame(input logic [7:0] mask, input logic [31:0] t,
                                          input logic [8:0] rng, input level_t lvl);
        item_t       fr;
        int unsigned thr;
        thr = steer_cfg.dark_threshold;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            case (lvl)
                LVL_EXTREME: fr.sample[i] = mask[i] ? 10'd1023 : 10'd0;
                LVL_EDGE:    fr.sample[i] = mask[i] ?
                                 ((thr == 1023) ? 10'd1023 : 10'(thr + 1)) :
                                 10'(thr);
                LVL_RAW:     fr.sample[i] = 10'($urandom_range(0, 1023));
                default:     fr.sample[i] = mask[i] ?
                                 ((thr == 1023) ? 10'd1023 :
                                  10'($urandom_range(thr + 1, 1023))) :
                                 10'($urandom_range(0, thr));
            endcase
        end
        fr.now_ms   = t;
        fr.range_cm = rng;
        return fr;
    endfunction

    // no long time jumps while a square is being timed
    function automatic logic [31:0] next_ms();
        if (!sq_timing && $urandom_range(39) == 0)
            track_ms = $urandom();
        else
            track_ms = track_ms + $urandom_range(0, 15);
        return track_ms;
    endfunction

    function automatic seg_t pick_segment();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 30) return SEG_STRAIGHT;
        if (roll < 45) return SEG_RIGHT;
        if (roll < 60) return SEG_LEFT;
        if (roll < 70) return SEG_DEAD_END;
        if (roll < 78) return SEG_SQUARE;
        if (roll < 86) return SEG_OBSTACLE;
        return SEG_NOISE;
    endfunction

    function automatic logic [7:0] track_mask(input seg_t seg);
        logic [7:0] mask;
        logic [1:0] ctr;
        ctr = 2'($urandom_range(1, 3));
        case (seg)
            SEG_STRAIGHT: mask = {3'b000, ctr, 3'b000};
            SEG_RIGHT:    mask = {3'b000, 2'($urandom_range(0, 3)), 3'($urandom_range(1, 7))};
            SEG_LEFT:     mask = {3'($urandom_range(1, 7)), 2'($urandom_range(0, 3)), 3'b000};
            SEG_DEAD_END: mask = 8'h00;
            SEG_SQUARE:
            begin
                mask = 8'hFF;
                mask &= ~(8'd1 << $urandom_range(7));
                mask &= ~(8'd1 << $urandom_range(7));
            end
            SEG_OBSTACLE: mask = ($urandom_range(1) == 0) ? {3'b000, ctr, 3'b000}
                                                          : 8'($urandom_range(255));
            default:      mask = 8'($urandom_range(255));
        endcase
        return mask;
    endfunction

    function automatic logic [8:0] pick_range(input seg_t seg);
        int unsigned roll;
        roll = $urandom_range(99);
        if (seg == SEG_OBSTACLE) return 9'($urandom_range(0, 40));
        if (roll < 45) return 9'd0;
        if (roll < 85) return 9'($urandom_range(100, 510));
        return 9'($urandom_range(0, 510));
    endfunction

    // channel and register access
    task automatic send_frame(input item_t fr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.sample_0 <= fr.sample[0];
        in_ch.sample_1 <= fr.sample[1];
        in_ch.sample_2 <= fr.sample[2];
        in_ch.sample_3 <= fr.sample[3];
        in_ch.sample_4 <= fr.sample[4];
        in_ch.sample_5 <= fr.sample[5];
        in_ch.sample_6 <= fr.sample[6];
        in_ch.sample_7 <= fr.sample[7];
        in_ch.now_ms   <= fr.now_ms;
        in_ch.range_cm <= fr.range_cm;
        do @(posedge clk); while (!in_ch.ready);
        expected_cmds.push_back(steer_predict(fr));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_DARK_THRESHOLD:  steer_cfg.dark_threshold      = value[9:0];
            REG_FINISH_MIN_DARK: steer_cfg.finish_min_dark     = value[3:0];
            REG_FINISH_HOLD_MS:  steer_cfg.finish_hold_ms      = value[15:0];
            REG_OBSTACLE_LIMIT:  steer_cfg.obstacle_limit_cm   = value[8:0];
            REG_CHECK_INTERVAL:  steer_cfg.check_interval_ms   = value[15:0];
            REG_TURN_COMMIT:     steer_cfg.turn_commit_steps   = value[7:0];
            REG_RIGHT_CONFIRM:   steer_cfg.right_confirm_steps = value[2:0];
            default: ;
        endcase
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_settings(input cfg_t c);
        write_reg(REG_DARK_THRESHOLD,  32'(c.dark_threshold));
        write_reg(REG_FINISH_MIN_DARK, 32'(c.finish_min_dark));
        write_reg(REG_FINISH_HOLD_MS,  32'(c.finish_hold_ms));
        write_reg(REG_OBSTACLE_LIMIT,  32'(c.obstacle_limit_cm));
        write_reg(REG_CHECK_INTERVAL,  32'(c.check_interval_ms));
        write_reg(REG_TURN_COMMIT,     32'(c.turn_commit_steps));
        write_reg(REG_RIGHT_CONFIRM,   32'(c.right_confirm_steps));
        apb_release();
    endtask

    // tests
    task automatic test_steering_basics();
        write_reg(REG_TURN_COMMIT, 3);
        apb_release();
        send_frame(build_frame(8'b0001_1000, 32'd0,  9'd0,   LVL_EXTREME));
        send_frame(build_frame(8'b0000_0001, 32'd1,  9'd510, LVL_EXTREME));
        send_frame(build_frame(8'b0000_1100, 32'd2,  9'd0,   LVL_RANDOM));
        send_frame(build_frame(8'b0001_0000, 32'd3,  9'd0,   LVL_RANDOM));
        send_frame(build_frame(8'b0000_1000, 32'd4,  9'd0,   LVL_RANDOM));
        send_frame(build_frame(8'b0001_1000, 32'd5,  9'd0,   LVL_RANDOM));
        send_frame(build_frame(8'b1000_0000, 32'd6,  9'd0,   LVL_RANDOM));
        send_frame(build_frame(8'b0000_0000, 32'd7,  9'd0,   LVL_RANDOM));
        send_frame(build_frame(8'b0011_0000, 32'd8,  9'd0,   LVL_RANDOM));
        send_frame(build_frame(8'b0100_1000, 32'd9,  9'd0,   LVL_RANDOM));
        send_frame(build_frame(8'b0001_0000, 32'd10, 9'd0,   LVL_RANDOM));
        send_frame(build_frame(8'b0000_0000, 32'd11, 9'd0,   LVL_RANDOM));
        // close echo on an elapsed interval, then one inside the interval
        send_frame(build_frame(8'b0001_1000, 32'd100, 9'd12, LVL_RANDOM));
        send_frame(build_frame(8'b0001_1000, 32'd150, 9'd5,  LVL_RANDOM));
        send_frame(build_frame(8'b0000_0010, 32'd200, 9'd13, LVL_RANDOM));
        send_frame(build_frame(8'b0000_0000, 32'd300, 9'd0,  LVL_RANDOM));
        // timestamp wrap
        send_frame(build_frame(8'b0001_1000, 32'hFFFF_FFF0, 9'd1, LVL_RANDOM));
        // samples exactly at and just above the threshold
        send_frame(build_frame(8'hFF,        32'h0000_0050, 9'd300, LVL_EDGE));
        send_frame(build_frame(8'b0001_1111, 32'h0000_0060, 9'd299, LVL_EDGE));
        send_frame(build_frame(8'hFF,        32'h0000_0070, 9'd510, LVL_EXTREME));
        track_ms = 32'h0000_0070;
    endtask

    task automatic test_track_traffic(input cfg_t c, input int unsigned n_items);
        int unsigned sent;
        int unsigned seg_len;
        seg_t        seg;
        logic [7:0]  mask;
        level_t      lvl;
        wait_drained();
        load_settings(c);
        sent = 0;
        while (sent < n_items)
        begin
            seg     = pick_segment();
            seg_len = $urandom_range(1, 25);
            for (int k = 0; k < seg_len && sent < n_items; k++)
            begin
                mask = track_mask(seg);
                if ($urandom_range(9) == 0)
                    mask ^= 8'd1 << $urandom_range(7);
                if (seg == SEG_NOISE)
                    lvl = LVL_RAW;
                else if ($urandom_range(9) == 0)
                    lvl = LVL_EDGE;
                else
                    lvl = LVL_RANDOM;
                send_frame(build_frame(mask, next_ms(), pick_range(seg), lvl));
                sent++;
            end
        end
    endtask

    // a turn held long enough for the step counter to saturate
    task automatic test_turn_hold_saturation();
        logic [7:0] mask;
        wait_drained();
        load_settings(steer_settings(700, 8, 16'hFFFF, 20, 50, 255, 3));
        for (int k = 0; k < 300; k++)
        begin
            mask = {3'($urandom_range(1, 7)), 2'b00, 3'($urandom_range(0, 7))};
            send_frame(build_frame(mask, next_ms(), 9'd0, LVL_RANDOM));
        end
        for (int k = 0; k < 5; k++)
            send_frame(build_frame(8'b0001_1000, next_ms(), 9'd0, LVL_RANDOM));
    endtask

    task automatic test_finish_latch();
        logic [31:0] t0;
        wait_drained();
        load_settings(steer_settings(RST_DARK_THRESHOLD, RST_FINISH_MIN_DARK,
                                     RST_FINISH_HOLD_MS, RST_OBSTACLE_LIMIT,
                                     RST_CHECK_INTERVAL, RST_TURN_COMMIT,
                                     RST_RIGHT_CONFIRM));
        send_frame(build_frame(8'b0001_1000, next_ms(), 9'd0, LVL_RANDOM));
        t0 = track_ms + 1;
        send_frame(build_frame(8'hFF,        t0,        9'd0, LVL_RANDOM));
        send_frame(build_frame(8'b1111_1100, t0 + 60,   9'd0, LVL_RANDOM));
        send_frame(build_frame(8'b0011_1111, t0 + 134,  9'd0, LVL_RANDOM));
        send_frame(build_frame(8'hFF,        t0 + 135,  9'd0, LVL_RANDOM));
        track_ms = t0 + 135;
        // everything after the latch answers hold
        for (int k = 0; k < 12; k++)
            send_frame(build_frame(8'($urandom_range(255)), next_ms(),
                                   9'($urandom_range(0, 510)), LVL_RAW));
    endtask

    // result checking and receiver throttling
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (expected_cmds.size() == 0)
                flag_error($sformatf("transaction %0d not expected: command %0d finished %0b",
                                     results_seen, out_ch.command, out_ch.finished));
            else
            begin
                want = expected_cmds.pop_front();
                if (out_ch.command !== want.command)
                    flag_error($sformatf("transaction %0d command: expected %0d got %0d",
                                         results_seen, want.command, out_ch.command));
                if (out_ch.finished !== want.finished)
                    flag_error($sformatf("transaction %0d finished: expected %0b got %0b",
                                         results_seen, want.finished, out_ch.finished));
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** line_follower_right_hand_steering: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.sample_0 = '0;
        in_ch.sample_1 = '0;
        in_ch.sample_2 = '0;
        in_ch.sample_3 = '0;
        in_ch.sample_4 = '0;
        in_ch.sample_5 = '0;
        in_ch.sample_6 = '0;
        in_ch.sample_7 = '0;
        in_ch.now_ms   = '0;
        in_ch.range_cm = '0;
        out_ch.ready   = 1'b0;
        error_count    = 0;
        results_seen   = 0;
        track_ms       = '0;
        send_idle_pct  = 13;
        recv_idle_pct  = 57;
        steer_cfg      = steer_settings(RST_DARK_THRESHOLD, RST_FINISH_MIN_DARK,
                                        RST_FINISH_HOLD_MS, RST_OBSTACLE_LIMIT,
                                        RST_CHECK_INTERVAL, RST_TURN_COMMIT,
                                        RST_RIGHT_CONFIRM);
        nav_done       = 1'b0;
        sq_timing      = 1'b0;
        sq_start_ms    = '0;
        last_check_ms  = '0;
        drop_navigation();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_steering_basics();
        test_track_traffic(steer_settings(512, 6, 16'hFFFF, 13, 100, 20, 2), 280);
        test_track_traffic(steer_settings(0, 0, 16'hFFFF, 0, 0, 0, 0), 280);

        send_idle_pct = 57;
        recv_idle_pct = 13;
        test_track_traffic(steer_settings(1023, 15, 0, 511, 16'hFFFF, 255, 7), 280);
        test_track_traffic(steer_settings(300, 9, 16'hFFFF, 300, 1, 1, 1), 280);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_track_traffic(steer_settings($urandom_range(100, 900), $urandom_range(3, 8),
                                          16'hFFFF, $urandom_range(0, 511),
                                          $urandom_range(0, 200), $urandom_range(1, 40),
                                          $urandom_range(1, 7)), 280);
        test_turn_hold_saturation();
        test_finish_latch();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_cmds.size() == 0)
            $display("** line_follower_right_hand_steering: PASSED **");
        else
            $display("** line_follower_right_hand_steering: FAILED **");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/lfrhs_pkg.sv
sv/lfrhs_if.sv
sv/lfrhs_cfg.sv
sv/lfrhs_core.sv
sv/line_follower_right_hand_steering.sv
verif/line_follower_right_hand_steering_test.sv
